### rtl/ple_pkg.sv
package ple_pkg;

  localparam int POS_W        = 7;
  localparam int VAL_W        = 32;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_APPEND     = 3'd1,
    OP_INS_AFTER  = 3'd2,
    OP_INS_BEFORE = 3'd3,
    OP_DELETE     = 3'd4,
    OP_FIND       = 3'd5,
    OP_COUNT      = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_INS_WR,
    S_SHIFT_DN,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

### rtl/positional_list_engine_unit.sv
// Ordered list of up to CAPACITY signed 32-bit values kept in one RAM with a
// registered read. One item at a time is processed; every item gives exactly
// one result. Clear and append go straight to the result; insert moves the
// tail from the target slot on up one entry per cycle through the RAM
// read/write port pair and writes the new value in a state of its own;
// delete moves the entries after the target down the same way; count makes
// one RAM read per stored entry and find stops at its first match, each
// compare working on the registered read data. A failed insert or delete and
// an unknown op go straight to the result too. The next item is accepted in
// the cycle after the result is loaded into the output register, even if
// that result has not yet been taken. No clearing pass is needed after
// reset: only entries below the length are ever read.
module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              op,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    ok,
  output logic [POS_W-1:0]        found_position,
  output logic [POS_W-1:0]        match_count,
  output logic [POS_W-1:0]        list_length
);

  localparam int LW = $clog2(CAPACITY + 1);   // holds 0..CAPACITY
  localparam int AW = $clog2(CAPACITY);       // RAM address
  localparam int CW = (LW > POS_W) ? LW : POS_W;

  state_t state, state_next;

  logic [LW-1:0]    length, length_next;
  logic [LW-1:0]    cur, cur_next;       // shift / scan cursor
  logic [LW-1:0]    idx, idx_next;       // slot being opened for insert
  logic             pend, pend_next;     // RAM read in flight
  logic [AW-1:0]    tag, tag_next;       // write address or scan index of that read
  op_t              op_q, op_q_next;
  logic [VAL_W-1:0] val_q, val_q_next;
  logic             ok_q, ok_q_next;
  logic             found, found_next;
  logic [LW-1:0]    fpos, fpos_next;
  logic [LW-1:0]    cnt, cnt_next;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic [CW-1:0]    pos_ext;
  logic [CW-1:0]    len_ext;
  logic             pos_valid;
  logic             has_room;
  logic             out_free;
  logic             load_out;
  logic             match;

  ple_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pos_ext   = CW'(position);
  assign len_ext   = CW'(length);
  assign pos_valid = (pos_ext != '0) && (pos_ext <= len_ext);
  assign has_room  = (length < LW'(CAPACITY));
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign match     = pend && (ram_rdata == val_q);

  always_comb begin
    state_next  = state;
    length_next = length;
    cur_next    = cur;
    idx_next    = idx;
    pend_next   = pend;
    tag_next    = tag;
    op_q_next   = op_q;
    val_q_next  = val_q;
    ok_q_next   = ok_q;
    found_next  = found;
    fpos_next   = fpos;
    cnt_next    = cnt;
    ram_we      = 1'b0;
    ram_waddr   = tag;
    ram_wdata   = ram_rdata;
    ram_raddr   = cur[AW-1:0];
    load_out    = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_q_next  = op_t'(op);
          val_q_next = value;
          ok_q_next  = 1'b0;
          found_next = 1'b0;
          fpos_next  = '0;
          cnt_next   = '0;
          pend_next  = 1'b0;
          state_next = S_FINISH;
          case (op_t'(op))
            OP_CLEAR: begin
              length_next = '0;
              ok_q_next   = 1'b1;
            end
            OP_APPEND: begin
              if (has_room) begin
                ram_we      = 1'b1;
                ram_waddr   = length[AW-1:0];
                ram_wdata   = value;
                length_next = length + 1'b1;
                ok_q_next   = 1'b1;
              end
            end
            OP_INS_AFTER, OP_INS_BEFORE: begin
              if (pos_valid && has_room) begin
                idx_next   = (op_t'(op) == OP_INS_AFTER) ? LW'(pos_ext)
                                                         : LW'(pos_ext - 1'b1);
                cur_next   = length;
                state_next = S_SHIFT_UP;
              end
            end
            OP_DELETE: begin
              if (pos_valid) begin
                cur_next   = LW'(pos_ext);   // first entry to move down
                state_next = S_SHIFT_DN;
              end
            end
            OP_FIND, OP_COUNT: begin
              cur_next   = '0;
              state_next = S_SCAN;
            end
            default: ;
          endcase
        end
      end

      // entries[cur] = entries[cur-1] going down to idx; write trails read
      S_SHIFT_UP: begin
        ram_we = pend;
        if (cur > idx) begin
          ram_raddr = AW'(cur - 1'b1);
          tag_next  = cur[AW-1:0];
          cur_next  = cur - 1'b1;
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          state_next = S_INS_WR;
        end
      end

      S_INS_WR: begin
        ram_we      = 1'b1;
        ram_waddr   = idx[AW-1:0];
        ram_wdata   = val_q;
        length_next = length + 1'b1;
        ok_q_next   = 1'b1;
        state_next  = S_FINISH;
      end

      // entries[cur-1] = entries[cur] going up to length-1
      S_SHIFT_DN: begin
        ram_we = pend;
        if (cur < length) begin
          ram_raddr = cur[AW-1:0];
          tag_next  = AW'(cur - 1'b1);
          cur_next  = cur + 1'b1;
          pend_next = 1'b1;
        end else begin
          pend_next   = 1'b0;
          length_next = length - 1'b1;
          ok_q_next   = 1'b1;
          state_next  = S_FINISH;
        end
      end

      S_SCAN: begin
        if (match) begin
          if (op_q == OP_COUNT) begin
            cnt_next = cnt + 1'b1;
          end else if (!found) begin
            found_next = 1'b1;
            fpos_next  = LW'(tag) + 1'b1;
          end
        end
        if (cur < length && !(op_q == OP_FIND && (found || match))) begin
          ram_raddr = cur[AW-1:0];
          tag_next  = cur[AW-1:0];
          cur_next  = cur + 1'b1;
          pend_next = 1'b1;
        end else begin
          pend_next  = 1'b0;
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      length <= length_next;
      pend   <= pend_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    cur   <= cur_next;
    idx   <= idx_next;
    tag   <= tag_next;
    op_q  <= op_q_next;
    val_q <= val_q_next;
    ok_q  <= ok_q_next;
    found <= found_next;
    fpos  <= fpos_next;
    cnt   <= cnt_next;
    if (load_out) begin
      case (op_q)
        OP_FIND:  ok <= found;
        OP_COUNT: ok <= (cnt != '0);
        default:  ok <= ok_q;
      endcase
      found_position <= POS_W'(fpos);
      match_count    <= POS_W'(cnt);
      list_length    <= POS_W'(length);
    end
  end

endmodule

### rtl/ple_ram.sv
// Simple dual-port RAM, one write port, one registered read port.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/testbench.sv
module testbench
  import ple_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP            = CAPACITY_DEF;
  localparam int RANDOM_ITEMS   = 675;
  localparam int QUIET_LIMIT    = 4000;  // cycles with no handshake on either side
  localparam int HOLD_CYCLES    = 400;   // long output stall to back the block up
  localparam int HOLD_AFTER     = 300;   // items accepted before the long stall
  localparam int CALM_TAIL      = 80;    // last items run with no idling
  localparam int DRAIN_CYCLES   = 100;
  localparam int MAX_REPORTS    = 40;

  // Op code 7 has no package name; the block ignores it but still answers.
  localparam logic [2:0] OP_RESERVED = 3'd7;

  typedef struct packed {
    logic [2:0]        op;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;
  } list_cmd_t;

  typedef struct packed {
    logic              ok;
    logic [POS_W-1:0]  found_position;
    logic [POS_W-1:0]  match_count;
    logic [POS_W-1:0]  list_length;
  } list_rsp_t;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} gen_mode_t;

  // ---------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------
  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic [2:0]              op        = '0;
  logic [POS_W-1:0]        position  = '0;
  logic signed [VAL_W-1:0] value     = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    ok;
  logic [POS_W-1:0]        found_position;
  logic [POS_W-1:0]        match_count;
  logic [POS_W-1:0]        list_length;

  positional_list_engine_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .position       (position),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .found_position (found_position),
    .match_count    (match_count),
    .list_length    (list_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow list: contents and length as the block should hold them
  // ---------------------------------------------------------------------
  logic [VAL_W-1:0] list_mem [CAP];
  int               shadow_len;

  list_cmd_t cmd_q[$];           // items waiting to be driven
  list_rsp_t expected_rsp_q[$];  // results owed by the block, oldest first

  int n_accepted;
  int n_results;
  int n_mismatch;
  int total_items;
  int full_reached;
  int full_rejects;
  int max_len_seen;
  int hold_left;
  bit hold_done;
  int quiet_cycles;

  // Generator side only tracks the length, to aim positions at live entries.
  int gen_len;

  // Apply one item to the shadow list and return the result it owes.
  function automatic list_rsp_t list_apply(list_cmd_t c);
    list_rsp_t r;
    int        p;
    int        slot;
    int        i;
    int        hits;
    bit        pos_ok;
    bit        room;
    r      = '0;
    p      = c.position;
    hits   = 0;
    pos_ok = (p >= 1) && (p <= shadow_len);
    room   = shadow_len < CAP;
    case (c.op)
      OP_CLEAR: begin
        shadow_len = 0;
        r.ok       = 1'b1;
      end
      OP_APPEND: begin
        if (room) begin
          list_mem[shadow_len] = c.value;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      OP_INS_AFTER, OP_INS_BEFORE: begin
        if (pos_ok && room) begin
          slot = (c.op == OP_INS_AFTER) ? p : p - 1;
          for (i = shadow_len; i > slot; i--) list_mem[i] = list_mem[i-1];
          list_mem[slot] = c.value;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos_ok) begin
          for (i = p - 1; i + 1 < shadow_len; i++) list_mem[i] = list_mem[i+1];
          shadow_len--;
          r.ok = 1'b1;
        end
      end
      OP_FIND: begin
        for (i = 0; i < shadow_len; i++) begin
          if (!r.ok && list_mem[i] == c.value) begin
            r.found_position = POS_W'(i + 1);
            r.ok             = 1'b1;
          end
        end
      end
      OP_COUNT: begin
        for (i = 0; i < shadow_len; i++) begin
          if (list_mem[i] == c.value) hits++;
        end
        r.match_count = POS_W'(hits);
        r.ok          = (hits != 0);
      end
      default: ;
    endcase
    r.list_length = POS_W'(shadow_len);
    return r;
  endfunction

  // Idling is on in stretches, off in others, and off for the final items.
  function automatic bit idling_allowed();
    return (n_accepted < total_items - CALM_TAIL) && (((n_accepted / 60) % 4) != 3);
  endfunction

  // Values lean on a small pool so that find and count hit often.
  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4, 5, 6: return VAL_W'($urandom_range(1, 6));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_mismatch < MAX_REPORTS)
      $display("%0t: result %0d, %s: got %0d, want %0d", $time, n_results, what, got, want);
    n_mismatch++;
  endtask

  // Queue an item and keep the generator's length in step with it.
  task automatic queue_cmd(input logic [2:0] o, input int p, input logic [VAL_W-1:0] v);
    list_cmd_t c;
    bit        pos_ok;
    c.op       = o;
    c.position = POS_W'(p);
    c.value    = v;
    cmd_q.push_back(c);
    pos_ok = (c.position >= 1) && (c.position <= gen_len);
    case (o)
      OP_CLEAR:                    gen_len = 0;
      OP_APPEND:                   if (gen_len < CAP) gen_len++;
      OP_INS_AFTER, OP_INS_BEFORE: if (pos_ok && gen_len < CAP) gen_len++;
      OP_DELETE:                   if (pos_ok) gen_len--;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Driver: one item on the bus at a time, random gaps between items
  // ---------------------------------------------------------------------
  list_cmd_t next_cmd;
  list_cmd_t bus_cmd;
  int        send_gap;
  int        len_before;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        bus_cmd    = {op, position, value};
        len_before = shadow_len;
        expected_rsp_q.push_back(list_apply(bus_cmd));
        if (len_before == CAP &&
            (bus_cmd.op == OP_APPEND || bus_cmd.op == OP_INS_AFTER ||
             bus_cmd.op == OP_INS_BEFORE))
          full_rejects++;
        if (shadow_len == CAP && len_before != CAP) full_reached++;
        if (shadow_len > max_len_seen) max_len_seen = shadow_len;
        n_accepted++;
      end
      // Bus is free after this edge: offer the next item or idle.
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (cmd_q.size() != 0) begin
          next_cmd = cmd_q.pop_front();
          op       <= next_cmd.op;
          position <= next_cmd.position;
          value    <= next_cmd.value;
          in_valid <= 1'b1;
          if (idling_allowed() && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Long output stall, once, so the block backs up and stops taking items
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check each result against the oldest expectation
  // ---------------------------------------------------------------------
  list_rsp_t want_rsp;
  int        recv_gap;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("result with no item pending", 1, 0);
        end else begin
          want_rsp = expected_rsp_q.pop_front();
          if (ok !== want_rsp.ok)
            report_mismatch("ok", ok, want_rsp.ok);
          if (found_position !== want_rsp.found_position)
            report_mismatch("found_position", found_position, want_rsp.found_position);
          if (match_count !== want_rsp.match_count)
            report_mismatch("match_count", match_count, want_rsp.match_count);
          if (list_length !== want_rsp.list_length)
            report_mismatch("list_length", list_length, want_rsp.list_length);
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        out_ready <= 1'b0;
        recv_gap--;
      end else begin
        out_ready <= 1'b1;
        if (idling_allowed() && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 15);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: too long with nothing moving on either side
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("positional_list_engine_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin : stimulus
    gen_mode_t  mode;
    int         n;
    int         r;
    int         p;
    int         full_streak;
    logic [2:0] o;

    gen_len     = 0;
    total_items = 1 << 30;  // keeps idling on until the real total is known

    // Directed: empty list, extreme values, both ends, bad positions.
    queue_cmd(OP_FIND,       0,   32'd5);          // find on empty list
    queue_cmd(OP_COUNT,      0,   32'd5);          // count on empty list
    queue_cmd(OP_INS_BEFORE, 1,   32'd1);          // no valid position yet
    queue_cmd(OP_INS_AFTER,  1,   32'd1);
    queue_cmd(OP_DELETE,     1,   32'd0);
    queue_cmd(OP_RESERVED,   127, '1);             // ignored op still answers
    queue_cmd(OP_APPEND,     0,   32'h8000_0000);
    queue_cmd(OP_APPEND,     0,   32'h7fff_ffff);
    queue_cmd(OP_APPEND,     127, 32'd0);
    queue_cmd(OP_INS_BEFORE, 1,   '1);             // new head
    queue_cmd(OP_INS_AFTER,  4,   '1);             // new tail
    queue_cmd(OP_INS_AFTER,  0,   32'd9);          // position zero
    queue_cmd(OP_INS_BEFORE, 6,   32'd9);          // one past the end
    queue_cmd(OP_DELETE,     0,   32'd0);
    queue_cmd(OP_DELETE,     127, 32'd0);
    queue_cmd(OP_FIND,       0,   '1);             // first of two matches
    queue_cmd(OP_COUNT,      0,   '1);
    queue_cmd(OP_FIND,       0,   32'd0);
    queue_cmd(OP_FIND,       0,   32'd12345);      // miss
    queue_cmd(OP_COUNT,      0,   32'd7);          // miss
    queue_cmd(OP_DELETE,     1,   32'd0);          // head
    queue_cmd(OP_DELETE,     4,   32'd0);          // tail
    queue_cmd(OP_INS_BEFORE, 3,   32'h7fff_ffff);
    queue_cmd(OP_CLEAR,      0,   32'd0);
    queue_cmd(OP_COUNT,      0,   32'd0);

    // Random: grow to full and linger, shrink to empty, or mix, plus noise.
    mode        = MODE_GROW;
    full_streak = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 5) begin
        queue_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 127), $urandom);
      end else begin
        r = $urandom_range(0, 99);
        case (mode)
          MODE_GROW:
            o = (r < 45) ? OP_APPEND : (r < 60) ? OP_INS_AFTER : (r < 75) ? OP_INS_BEFORE :
                (r < 80) ? OP_DELETE : (r < 90) ? OP_FIND : OP_COUNT;
          MODE_SHRINK:
            o = (r < 55) ? OP_DELETE : (r < 65) ? OP_INS_BEFORE :
                (r < 80) ? OP_FIND : OP_COUNT;
          default:
            o = (r < 2) ? OP_CLEAR : 3'($urandom_range(1, 6));
        endcase
        r = $urandom_range(0, 19);
        if (o == OP_FIND || o == OP_COUNT || o == OP_CLEAR || o == OP_APPEND)
          p = $urandom_range(0, 127);
        else if (r == 0)
          p = 0;
        else if (r == 1)
          p = gen_len + 1;
        else if (r == 2)
          p = 1;
        else if (r == 3 && gen_len > 0)
          p = gen_len;
        else
          p = $urandom_range(1, (gen_len > 0) ? gen_len : 1);
        queue_cmd(o, p, pick_value());
      end
      case (mode)
        MODE_GROW: begin
          if (gen_len == CAP) full_streak++;
          if (full_streak >= 6) begin
            full_streak = 0;
            mode = ($urandom_range(0, 1) != 0) ? MODE_SHRINK : MODE_MIX;
          end
        end
        MODE_SHRINK: if (gen_len == 0) mode = MODE_GROW;
        default: begin
          r = $urandom_range(0, 49);
          if (r == 0) mode = MODE_GROW;
          else if (r == 1) mode = MODE_SHRINK;
        end
      endcase
    end
    total_items = cmd_q.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d items, checked %0d results, %0d mismatches", n_accepted, n_results,
             n_mismatch);
    $display("list filled to capacity %0d times (max length %0d), %0d inserts refused when full",
             full_reached, max_len_seen, full_rejects);
    if (n_mismatch == 0) begin
      $display("positional_list_engine_unit verification clean");
    end else begin
      $display("positional_list_engine_unit verification failed");
    end
    $finish;
  end

endmodule
